// ----- hw/rtl/cesp_pkg.sv -----
// ----------------------------------------------------------------------------
// cesp_pkg
// Shared constants, codes and the byte classifier of the CSI escape parser.
// ----------------------------------------------------------------------------
package cesp_pkg;

  localparam int DEF_MAX_PARAMS = 8;
  localparam int DEF_PARAM_BITS = 16;
  localparam int ARG_BITS       = 16;
  localparam int FINAL_ARGS     = 5;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_DIGIT_0  = 8'h30;
  localparam logic [7:0] CH_DIGIT_9  = 8'h39;
  localparam logic [7:0] CH_UPPER_D  = 8'h44;
  localparam logic [7:0] CH_UPPER_C  = 8'h43;
  localparam logic [7:0] CH_UPPER_J  = 8'h4A;
  localparam logic [7:0] CH_UPPER_H  = 8'h48;
  localparam logic [7:0] CH_LOWER_H  = 8'h68;
  localparam logic [7:0] CH_LOWER_L  = 8'h6C;
  localparam logic [7:0] CH_LOWER_M  = 8'h6D;

  localparam int ALT_SCREEN_CODE = 1049;
  localparam int SGR_FG_CODE     = 38;
  localparam int COLOR_TYPE_RGB  = 2;
  localparam int CUP_COUNT       = 2;
  localparam int ALT_COUNT       = 1;
  localparam int SGR_TYPE_COUNT  = 2;
  localparam int RGB_COUNT       = 5;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_LEFT      = 3'd1,
    CMD_RIGHT     = 3'd2,
    CMD_SET_CURSOR = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_ALT_ON    = 3'd5,
    CMD_ALT_OFF   = 3'd6,
    CMD_SET_COLOR = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ERR_NONE          = 4'd0,
    ERR_CUP_COUNT     = 4'd1,
    ERR_NO_PRIVATE    = 4'd2,
    ERR_BAD_PRIVATE   = 4'd3,
    ERR_NO_COLOR_TYPE = 4'd4,
    ERR_BAD_COLOR_TYPE = 4'd5,
    ERR_COLOR_COUNT   = 4'd6,
    ERR_BAD_SGR       = 4'd7,
    ERR_BAD_FINAL     = 4'd8
  } err_t;

  typedef struct packed {
    logic is_esc;
    logic is_intro;
    logic is_digit;
    logic is_semi;
    logic is_final;
  } byte_class_t;

  function automatic byte_class_t classify(input logic [7:0] ch);
    byte_class_t cls;
    cls.is_esc   = (ch == CH_ESC);
    cls.is_intro = (ch == CH_LBRACKET) || (ch == CH_QMARK);
    cls.is_digit = (ch >= CH_DIGIT_0) && (ch <= CH_DIGIT_9);
    cls.is_semi  = (ch == CH_SEMI);
    cls.is_final = !(cls.is_esc || cls.is_intro || cls.is_digit || cls.is_semi);
    return cls;
  endfunction

endpackage

// ----- hw/rtl/cesp_param_state.sv -----
// ----------------------------------------------------------------------------
// cesp_param_state
// Sequence state, parameter accumulator, parameter store and screen select.
// ----------------------------------------------------------------------------
module cesp_param_state #(
  parameter int MAX_PARAMS = cesp_pkg::DEF_MAX_PARAMS,
  parameter int PARAM_BITS = cesp_pkg::DEF_PARAM_BITS,
  localparam int CW = $clog2(MAX_PARAMS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  cesp_pkg::byte_class_t  cls,
  input  logic [7:0]             ch,
  input  logic                   alt_set,
  input  logic                   alt_clr,
  output logic                   in_sequence,
  output logic [CW-1:0]          final_count,
  output logic [cesp_pkg::FINAL_ARGS-1:0][PARAM_BITS-1:0] final_params,
  output logic                   alt_next
);
  import cesp_pkg::*;

  localparam int IW = $clog2(MAX_PARAMS);
  localparam int AW = PARAM_BITS + 4;

  logic [PARAM_BITS-1:0] current_value;
  logic [PARAM_BITS-1:0] param_store [MAX_PARAMS];
  logic [CW-1:0]         param_count;
  logic                  alt_active;

  logic                  room;
  logic                  push;
  logic [AW-1:0]         acc_ext;
  logic [AW-1:0]         acc_sum;
  logic [PARAM_BITS-1:0] current_value_next;

  always_comb begin
    room     = param_count < CW'(MAX_PARAMS);
    push     = step && in_sequence && !cls.is_esc && (cls.is_semi || cls.is_final);
    final_count = room ? param_count + CW'(1) : param_count;
    acc_ext  = {4'b0000, current_value};
    acc_sum  = (acc_ext << 3) + (acc_ext << 1) + AW'(ch[3:0]);
    current_value_next = (acc_sum[AW-1:PARAM_BITS] != 4'b0000) ? {PARAM_BITS{1'b1}}
                                                               : acc_sum[PARAM_BITS-1:0];
    for (int i = 0; i < FINAL_ARGS; i++) begin
      if (CW'(i) < param_count) begin
        final_params[i] = param_store[i];
      end else if (CW'(i) == param_count && room) begin
        final_params[i] = current_value;
      end else begin
        final_params[i] = '0;
      end
    end
    alt_next = alt_set ? 1'b1 : (alt_clr ? 1'b0 : alt_active);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sequence   <= 1'b0;
      current_value <= '0;
      param_count   <= '0;
      alt_active    <= 1'b0;
    end else if (step) begin
      alt_active <= alt_next;
      if (cls.is_esc) begin
        in_sequence <= 1'b1;
        param_count <= '0;
      end else if (in_sequence) begin
        if (cls.is_digit) begin
          current_value <= current_value_next;
        end else if (cls.is_semi || cls.is_final) begin
          current_value <= '0;
          param_count   <= final_count;
          if (cls.is_final) begin
            in_sequence <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && room) begin
      param_store[param_count[IW-1:0]] <= current_value;
    end
  end

endmodule

// ----- hw/rtl/cesp_cmd_decode.sv -----
// ----------------------------------------------------------------------------
// cesp_cmd_decode
// Final byte decode into command, arguments, error code and screen select.
// ----------------------------------------------------------------------------
module cesp_cmd_decode #(
  parameter int MAX_PARAMS = cesp_pkg::DEF_MAX_PARAMS,
  parameter int PARAM_BITS = cesp_pkg::DEF_PARAM_BITS,
  localparam int CW = $clog2(MAX_PARAMS + 1)
) (
  input  logic                   active,
  input  logic [7:0]             ch,
  input  logic [CW-1:0]          final_count,
  input  logic [cesp_pkg::FINAL_ARGS-1:0][PARAM_BITS-1:0] final_params,
  output cesp_pkg::cmd_t         command,
  output logic [cesp_pkg::ARG_BITS-1:0] arg_a,
  output logic [cesp_pkg::ARG_BITS-1:0] arg_b,
  output logic [cesp_pkg::ARG_BITS-1:0] arg_c,
  output cesp_pkg::err_t         error,
  output logic                   alt_set,
  output logic                   alt_clr
);
  import cesp_pkg::*;

  function automatic logic [ARG_BITS-1:0] to_arg(input logic [PARAM_BITS-1:0] p);
    logic [PARAM_BITS+ARG_BITS-1:0] wide;
    wide = {{ARG_BITS{1'b0}}, p};
    return wide[ARG_BITS-1:0];
  endfunction

  always_comb begin
    command = CMD_NONE;
    error   = ERR_NONE;
    arg_a   = '0;
    arg_b   = '0;
    arg_c   = '0;
    alt_set = 1'b0;
    alt_clr = 1'b0;
    if (active) begin
      case (ch)
        CH_UPPER_D: command = CMD_LEFT;
        CH_UPPER_C: command = CMD_RIGHT;
        CH_UPPER_J: command = CMD_CLEAR;
        CH_UPPER_H: begin
          if (final_count != CW'(CUP_COUNT)) begin
            error = ERR_CUP_COUNT;
          end else begin
            command = CMD_SET_CURSOR;
            arg_a   = to_arg(final_params[1]);
            arg_b   = to_arg(final_params[0]);
          end
        end
        CH_LOWER_H, CH_LOWER_L: begin
          if (final_count != CW'(ALT_COUNT)) begin
            error = ERR_NO_PRIVATE;
          end else if (final_params[0] != PARAM_BITS'(ALT_SCREEN_CODE)) begin
            error = ERR_BAD_PRIVATE;
          end else if (ch == CH_LOWER_H) begin
            command = CMD_ALT_ON;
            alt_set = 1'b1;
          end else begin
            command = CMD_ALT_OFF;
            alt_clr = 1'b1;
          end
        end
        CH_LOWER_M: begin
          if (final_params[0] != PARAM_BITS'(SGR_FG_CODE)) begin
            error = ERR_BAD_SGR;
          end else if (final_count < CW'(SGR_TYPE_COUNT)) begin
            error = ERR_NO_COLOR_TYPE;
          end else if (final_params[1] != PARAM_BITS'(COLOR_TYPE_RGB)) begin
            error = ERR_BAD_COLOR_TYPE;
          end else if (final_count != CW'(RGB_COUNT)) begin
            error = ERR_COLOR_COUNT;
          end else begin
            command = CMD_SET_COLOR;
            arg_a   = to_arg(final_params[2]);
            arg_b   = to_arg(final_params[3]);
            arg_c   = to_arg(final_params[4]);
          end
        end
        default: error = ERR_BAD_FINAL;
      endcase
    end
  end

endmodule

// ----- hw/rtl/csi_escape_sequence_parser.sv -----
// a byte accepted into the input register is decoded into the result register,
// where the receiver can take it; throughput: one byte per cycle unless out_ready
// holds a result back; classify, accumulate and decode share one
// register-to-register path from the input register to the result register
// reset clears the sequence state, parameter count, accumulator and screen
// select at once; the parameter store is not cleared
// ----------------------------------------------------------------------------
// csi_escape_sequence_parser
// Terminal byte parser for CSI escape sequences, one result per byte.
// ----------------------------------------------------------------------------
module csi_escape_sequence_parser #(
  parameter int MAX_PARAMS = cesp_pkg::DEF_MAX_PARAMS,
  parameter int PARAM_BITS = cesp_pkg::DEF_PARAM_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        consumed,
  output logic [2:0]  command,
  output logic [cesp_pkg::ARG_BITS-1:0] arg_a,
  output logic [cesp_pkg::ARG_BITS-1:0] arg_b,
  output logic [cesp_pkg::ARG_BITS-1:0] arg_c,
  output logic [3:0]  error,
  output logic        alternate_screen
);
  import cesp_pkg::*;

  localparam int CW = $clog2(MAX_PARAMS + 1);

  logic        hold_valid;
  logic [7:0]  hold_ch;
  logic        step;
  byte_class_t cls;

  logic        in_sequence;
  logic [CW-1:0] final_count;
  logic [FINAL_ARGS-1:0][PARAM_BITS-1:0] final_params;
  logic        alt_next;
  logic        alt_set;
  logic        alt_clr;
  cmd_t        dec_command;
  err_t        dec_error;
  logic [ARG_BITS-1:0] dec_a;
  logic [ARG_BITS-1:0] dec_b;
  logic [ARG_BITS-1:0] dec_c;

  assign step     = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || step;
  assign cls      = classify(hold_ch);

  cesp_param_state #(
    .MAX_PARAMS(MAX_PARAMS),
    .PARAM_BITS(PARAM_BITS)
  ) u_state (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .cls         (cls),
    .ch          (hold_ch),
    .alt_set     (alt_set),
    .alt_clr     (alt_clr),
    .in_sequence (in_sequence),
    .final_count (final_count),
    .final_params(final_params),
    .alt_next    (alt_next)
  );

  cesp_cmd_decode #(
    .MAX_PARAMS(MAX_PARAMS),
    .PARAM_BITS(PARAM_BITS)
  ) u_decode (
    .active      (in_sequence && cls.is_final),
    .ch          (hold_ch),
    .final_count (final_count),
    .final_params(final_params),
    .command     (dec_command),
    .arg_a       (dec_a),
    .arg_b       (dec_b),
    .arg_c       (dec_c),
    .error       (dec_error),
    .alt_set     (alt_set),
    .alt_clr     (alt_clr)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold_ch <= ch;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= step || (out_valid && !out_ready);
    end
    if (step) begin
      consumed         <= cls.is_esc || in_sequence;
      command          <= dec_command;
      arg_a            <= dec_a;
      arg_b            <= dec_b;
      arg_c            <= dec_c;
      error            <= dec_error;
      alternate_screen <= alt_next;
    end
  end

`ifndef SYNTHESIS
  a_plain_text_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !consumed |-> command == CMD_NONE && error == ERR_NONE)
    else $error("plain text request carries a command or error");

  a_cmd_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && command != CMD_NONE |-> error == ERR_NONE)
    else $error("command issued together with an error");

  a_alt_on_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_ALT_ON |-> alternate_screen)
    else $error("alternate screen not active after switch on");

  a_stall_only_on_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while result register is free");
`endif

endmodule

// ----- test/csi_parser_checker.sv -----
// ----------------------------------------------------------------------------
// csi_parser_checker
// Watches both channels of the CSI escape parser and keeps its own model of
// the parser state. Each accepted byte yields one expected result, and each
// delivered result is compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module csi_parser_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        consumed,
  input  logic [2:0]  command,
  input  logic [cesp_pkg::ARG_BITS-1:0] arg_a,
  input  logic [cesp_pkg::ARG_BITS-1:0] arg_b,
  input  logic [cesp_pkg::ARG_BITS-1:0] arg_c,
  input  logic [3:0]  error,
  input  logic        alternate_screen,
  output int          fail_count,
  output int          outstanding
);
  import cesp_pkg::*;

  localparam int unsigned PARAM_LIMIT = (1 << DEF_PARAM_BITS) - 1;

  typedef struct packed {
    logic                consumed;
    cmd_t                command;
    logic [ARG_BITS-1:0] arg_a;
    logic [ARG_BITS-1:0] arg_b;
    logic [ARG_BITS-1:0] arg_c;
    err_t                error;
    logic                alt;
  } screen_result_t;

  screen_result_t pending_results[$];
  int failures;

  logic                      seq_open;
  int unsigned               accum;
  logic [DEF_PARAM_BITS-1:0] param_list[DEF_MAX_PARAMS];
  int unsigned               nparams;
  logic                      alt_screen;

  function automatic int unsigned param_value(input int unsigned idx);
    return (idx < nparams) ? int'(param_list[idx]) : 0;
  endfunction

  function automatic void close_param();
    if (nparams < DEF_MAX_PARAMS) begin
      param_list[nparams] = accum[DEF_PARAM_BITS-1:0];
      nparams++;
    end
    accum = 0;
  endfunction

  function automatic screen_result_t decode_byte(input logic [7:0] b);
    screen_result_t r;
    int unsigned    acc;
    r = '0;
    r.consumed = 1'b1;
    r.command  = CMD_NONE;
    r.error    = ERR_NONE;
    if (b == CH_ESC) begin
      seq_open = 1'b1;
      nparams  = 0;
    end else if (!seq_open) begin
      r.consumed = 1'b0;
    end else if (b == CH_LBRACKET || b == CH_QMARK) begin
      r.consumed = 1'b1;
    end else if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) begin
      acc   = accum * 10 + int'(b - CH_DIGIT_0);
      accum = (acc > PARAM_LIMIT) ? PARAM_LIMIT : acc;
    end else if (b == CH_SEMI) begin
      close_param();
    end else begin
      close_param();
      seq_open = 1'b0;
      case (b)
        CH_UPPER_D: r.command = CMD_LEFT;
        CH_UPPER_C: r.command = CMD_RIGHT;
        CH_UPPER_J: r.command = CMD_CLEAR;
        CH_UPPER_H: begin
          if (nparams != CUP_COUNT) begin
            r.error = ERR_CUP_COUNT;
          end else begin
            r.command = CMD_SET_CURSOR;
            r.arg_a   = ARG_BITS'(param_value(1));
            r.arg_b   = ARG_BITS'(param_value(0));
          end
        end
        CH_LOWER_H, CH_LOWER_L: begin
          if (nparams != ALT_COUNT) begin
            r.error = ERR_NO_PRIVATE;
          end else if (param_value(0) != ALT_SCREEN_CODE) begin
            r.error = ERR_BAD_PRIVATE;
          end else if (b == CH_LOWER_H) begin
            alt_screen = 1'b1;
            r.command  = CMD_ALT_ON;
          end else begin
            alt_screen = 1'b0;
            r.command  = CMD_ALT_OFF;
          end
        end
        CH_LOWER_M: begin
          if (param_value(0) != SGR_FG_CODE) begin
            r.error = ERR_BAD_SGR;
          end else if (nparams < SGR_TYPE_COUNT) begin
            r.error = ERR_NO_COLOR_TYPE;
          end else if (param_value(1) != COLOR_TYPE_RGB) begin
            r.error = ERR_BAD_COLOR_TYPE;
          end else if (nparams != RGB_COUNT) begin
            r.error = ERR_COLOR_COUNT;
          end else begin
            r.command = CMD_SET_COLOR;
            r.arg_a   = ARG_BITS'(param_value(2));
            r.arg_b   = ARG_BITS'(param_value(3));
            r.arg_c   = ARG_BITS'(param_value(4));
          end
        end
        default: r.error = ERR_BAD_FINAL;
      endcase
    end
    r.alt = alt_screen;
    return r;
  endfunction

  always @(posedge clk) begin
    screen_result_t want;
    if (rst) begin
      seq_open   = 1'b0;
      accum      = 0;
      nparams    = 0;
      alt_screen = 1'b0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          if (failures < 10)
            $display("unexpected result at %0t: command %0d error %0d", $time, command, error);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (consumed !== want.consumed || command !== want.command ||
              arg_a !== want.arg_a || arg_b !== want.arg_b || arg_c !== want.arg_c ||
              error !== want.error || alternate_screen !== want.alt) begin
            if (failures < 10) begin
              $display("mismatch at %0t: consumed %0d/%0d command %0d/%0d error %0d/%0d",
                       $time, want.consumed, consumed, want.command, command,
                       want.error, error);
              $display("  args %0d,%0d,%0d / %0d,%0d,%0d alt %0d/%0d",
                       want.arg_a, want.arg_b, want.arg_c, arg_a, arg_b, arg_c,
                       want.alt, alternate_screen);
            end
            failures++;
          end
        end
      end
      // one result per accepted request
      if (in_valid && in_ready)
        pending_results.push_back(decode_byte(ch));
    end
    fail_count  <= failures;
    outstanding <= pending_results.size();
  end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives the CSI escape parser with a short directed byte stream and then
// random escape sequences, mostly well formed with random parameters, mixed
// with plain text, broken and overlong sequences. Both sides idle at random
// in phases; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import cesp_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  ch;
  logic        out_valid;
  logic        out_ready;
  logic        consumed;
  logic [2:0]  command;
  logic [ARG_BITS-1:0] arg_a;
  logic [ARG_BITS-1:0] arg_b;
  logic [ARG_BITS-1:0] arg_c;
  logic [3:0]  error;
  logic        alternate_screen;
  int          fail_count;
  int          outstanding;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned seq_bytes;

  csi_escape_sequence_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .ch(ch),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .consumed(consumed),
    .command(command),
    .arg_a(arg_a),
    .arg_b(arg_b),
    .arg_c(arg_c),
    .error(error),
    .alternate_screen(alternate_screen)
  );

  csi_parser_checker checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .ch(ch),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .consumed(consumed),
    .command(command),
    .arg_a(arg_a),
    .arg_b(arg_b),
    .arg_c(arg_c),
    .error(error),
    .alternate_screen(alternate_screen),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    ch        = 8'h00;
    out_ready = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    seq_bytes = 0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input bit counted);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counted) seq_bytes++;
  endtask

  task automatic send_number(input int unsigned v);
    logic [7:0]  digs[$];
    int unsigned x;
    x = v;
    do begin
      digs.push_front(CH_DIGIT_0 + 8'(x % 10));
      x = x / 10;
    end while (x != 0);
    if ($urandom_range(15) == 0) send_byte(CH_DIGIT_0, 1);
    foreach (digs[i]) send_byte(digs[i], 1);
  endtask

  function automatic bit is_final_byte(input logic [7:0] b);
    return !(b == CH_ESC || b == CH_LBRACKET || b == CH_QMARK || b == CH_SEMI ||
             (b >= CH_DIGIT_0 && b <= CH_DIGIT_9));
  endfunction

  function automatic logic [7:0] any_final();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (!is_final_byte(b));
    return b;
  endfunction

  function automatic logic [7:0] pick_final();
    case ($urandom_range(0, 7))
      0: return CH_UPPER_D;
      1: return CH_UPPER_C;
      2: return CH_UPPER_J;
      3: return CH_UPPER_H;
      4: return CH_LOWER_H;
      5: return CH_LOWER_L;
      6: return CH_LOWER_M;
      default: return any_final();
    endcase
  endfunction

  function automatic int unsigned rand_param();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(65530, 9999999);
      2: return 65535;
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  function automatic int unsigned rand_color();
    return ($urandom_range(3) == 0) ? rand_param() : $urandom_range(0, 255);
  endfunction

  task automatic send_sequence();
    int unsigned vals[$];
    logic [7:0]  fin;
    int unsigned n;
    send_byte(CH_ESC, 1);
    if ($urandom_range(9) != 0) send_byte(CH_LBRACKET, 1);
    case ($urandom_range(0, 11))
      0, 1: begin
        case ($urandom_range(2))
          0: fin = CH_UPPER_D;
          1: fin = CH_UPPER_C;
          default: fin = CH_UPPER_J;
        endcase
        if ($urandom_range(1)) vals.push_back($urandom_range(0, 20));
      end
      2, 3: begin
        fin = CH_UPPER_H;
        n = ($urandom_range(3) != 0) ? CUP_COUNT : $urandom_range(0, 4);
        repeat (n) vals.push_back(rand_param());
      end
      4, 5: begin
        if ($urandom_range(3) != 0) send_byte(CH_QMARK, 1);
        fin = $urandom_range(1) ? CH_LOWER_H : CH_LOWER_L;
        case ($urandom_range(0, 5))
          0: ;
          1: begin
            vals.push_back(ALT_SCREEN_CODE);
            vals.push_back(rand_param());
          end
          2: vals.push_back(rand_param());
          default: vals.push_back(ALT_SCREEN_CODE);
        endcase
      end
      6, 7, 8: begin
        fin = CH_LOWER_M;
        case ($urandom_range(0, 7))
          0: repeat ($urandom_range(1, 5)) vals.push_back(rand_param());
          1: vals.push_back(SGR_FG_CODE);
          2: begin
            vals.push_back(SGR_FG_CODE);
            vals.push_back($urandom_range(1) ? rand_param() : COLOR_TYPE_RGB + 3);
            repeat ($urandom_range(0, 3)) vals.push_back(rand_color());
          end
          3: begin
            vals.push_back(SGR_FG_CODE);
            vals.push_back(COLOR_TYPE_RGB);
            n = $urandom_range(0, 5);
            if (n == 3) n = 4;
            repeat (n) vals.push_back(rand_color());
          end
          default: begin
            vals.push_back(SGR_FG_CODE);
            vals.push_back(COLOR_TYPE_RGB);
            repeat (3) vals.push_back(rand_color());
          end
        endcase
      end
      9: begin
        repeat ($urandom_range(0, 3)) vals.push_back(rand_param());
        fin = any_final();
      end
      10: begin
        repeat ($urandom_range(DEF_MAX_PARAMS, DEF_MAX_PARAMS + 4))
          vals.push_back(rand_param());
        fin = pick_final();
      end
      default: begin
        // restart in the middle of a sequence with a number half built
        repeat ($urandom_range(0, 2)) begin
          send_number(rand_param());
          send_byte(CH_SEMI, 1);
        end
        send_number($urandom_range(1, 9999));
        send_byte(CH_ESC, 1);
        if ($urandom_range(1)) send_byte(CH_LBRACKET, 1);
        repeat ($urandom_range(0, 4)) vals.push_back(rand_param());
        fin = pick_final();
      end
    endcase
    foreach (vals[i]) begin
      if (i != 0) send_byte(CH_SEMI, 1);
      if (vals[i] != 0 || $urandom_range(3) != 0) send_number(vals[i]);
    end
    send_byte(fin, 1);
  endtask

  initial begin
    int unsigned phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00, 0);
    send_byte(8'hFF, 0);
    send_byte(8'h41, 0);
    send_byte(CH_ESC, 1);
    send_byte(CH_LBRACKET, 1);
    repeat (6) send_byte(CH_DIGIT_9, 1);
    send_byte(CH_SEMI, 1);
    send_byte(CH_DIGIT_0, 1);
    send_byte(CH_UPPER_H, 1);
    send_byte(CH_ESC, 1);
    send_byte(CH_QMARK, 1);
    send_number(ALT_SCREEN_CODE);
    send_byte(CH_LOWER_H, 1);
    send_byte(CH_ESC, 1);
    send_byte(CH_UPPER_D, 1);

    while (seq_bytes < 1800) begin
      phase = (seq_bytes / 150) % 4;
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 68; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 68; end
        default: begin idle_pct = 11; stall_pct <= 11; end
      endcase
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), 0);
      end else begin
        send_sequence();
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/cesp_pkg.sv
hw/rtl/cesp_param_state.sv
hw/rtl/cesp_cmd_decode.sv
hw/rtl/csi_escape_sequence_parser.sv
test/csi_parser_checker.sv
test/tb.sv
